// ----- hdl/hfe_pkg.sv -----
package hfe_pkg;

  localparam int MAX_DATA_BITS = 57;
  localparam int CW_W = 63;
  localparam int M_W = 6;

  localparam logic [1:0] TYPE_FLAG = 2'd0;
  localparam logic [1:0] TYPE_ESC = 2'd1;
  localparam logic [1:0] TYPE_DATA = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPEN_FLAG,
    ST_SHIFT,
    ST_FRAME,
    ST_DATA,
    ST_CLOSE_FLAG
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic bit_in;
  } enc_ctl_t;

  typedef struct packed {
    logic [CW_W-1:0] word;
    logic [M_W-1:0]  fill;
    logic            all_zero;
    logic            all_one;
  } enc_status_t;

  function automatic logic [M_W-1:0] eff_m(input logic [M_W-1:0] v);
    logic [M_W-1:0] m;
    m = v;
    if (m == '0) m = M_W'(1);
    if (m > M_W'(MAX_DATA_BITS)) m = M_W'(MAX_DATA_BITS);
    return m;
  endfunction

  function automatic logic [2:0] parity_count(input logic [M_W-1:0] m);
    logic [2:0] r;
    int i;
    r = '0;
    for (i = 0; i < 7; i++) begin
      if (int'(m) + int'(r) + 1 > (1 << r)) r = r + 3'd1;
    end
    return r;
  endfunction

  function automatic logic [M_W-1:0] cw_len(input logic [M_W-1:0] m);
    return m + M_W'(parity_count(m));
  endfunction

  function automatic logic [CW_W-1:0] flag_word(input logic [M_W-1:0] m);
    logic [CW_W-1:0] w;
    logic [M_W-1:0]  n;
    logic            p;
    int              pos;
    int              k;
    n = cw_len(m);
    w = '0;
    for (pos = 1; pos <= CW_W; pos++) begin
      if (pos <= int'(n) && (pos & (pos - 1)) != 0) w[pos-1] = 1'b1;
    end
    for (k = 0; k < M_W; k++) begin
      p = 1'b0;
      for (pos = 1; pos <= CW_W; pos++) begin
        if ((pos & (1 << k)) != 0) p = p ^ w[pos-1];
      end
      w[(1 << k) - 1] = w[(1 << k) - 1] | p;
    end
    return w;
  endfunction

endpackage

// ----- hdl/hfe_serial_encoder.sv -----
module hfe_serial_encoder (
  input  logic                clk,
  input  logic                rst,
  input  hfe_pkg::enc_ctl_t   ctl,
  output hfe_pkg::enc_status_t status
);
  import hfe_pkg::*;

  logic [CW_W-1:0] cw;
  logic [M_W-1:0]  par;
  logic [M_W:0]    pos;
  logic [M_W-1:0]  fill;
  logic            all_zero;
  logic            all_one;

  logic [M_W:0]    pos_inc;
  logic [M_W:0]    pos_next;
  logic [CW_W-1:0] word;

  always_comb begin
    pos_inc = pos + (M_W+1)'(1);
    if ((pos_inc & (pos_inc - (M_W+1)'(1))) == '0) begin
      pos_next = pos_inc + (M_W+1)'(1);
    end else begin
      pos_next = pos_inc;
    end
  end

  always_comb begin
    word = cw;
    for (int k = 0; k < M_W; k++) begin
      word[(1 << k) - 1] = par[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      cw <= '0;
      par <= '0;
      pos <= (M_W+1)'(3);
      fill <= '0;
      all_zero <= 1'b1;
      all_one <= 1'b1;
    end else if (ctl.shift) begin
      cw[M_W'(pos - (M_W+1)'(1))] <= ctl.bit_in;
      if (ctl.bit_in) par <= par ^ pos[M_W-1:0];
      pos <= pos_next;
      fill <= fill + M_W'(1);
      all_zero <= all_zero & ~ctl.bit_in;
      all_one <= all_one & ctl.bit_in;
    end
  end

  assign status.word = word;
  assign status.fill = fill;
  assign status.all_zero = all_zero;
  assign status.all_one = all_one;

endmodule

// ----- hdl/hamming_frame_encoder_with_escape.sv -----
// Hamming frame encoder with flag and escape framing. Message bytes are
// taken on the message channel and shifted into the frame encoder one bit
// per clock, most significant bit first, pausing while a finished frame is
// pushed; each frame of data_bits data bits is built into a Hamming codeword
// as its bits arrive, parity included. Each frame that a byte closes passes
// a frame check, which pushes an escape frame if one is needed, and then a
// data push, and every push waits while the result channel stalls. A
// message opens with a flag frame and closes with one; an all-zero data
// frame, or a full all-one data frame, is preceded by an escape frame.
// Writing data_bits discards any partial frame.
module hamming_frame_encoder_with_escape (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         data_bits_write,
  input  logic [hfe_pkg::M_W-1:0]      data_bits,
  input  logic                         message_valid,
  output logic                         message_ready,
  input  logic [7:0]                   message_byte,
  input  logic                         end_of_message,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [hfe_pkg::CW_W-1:0]     codeword,
  output logic [hfe_pkg::M_W-1:0]      codeword_length,
  output logic [1:0]                   frame_type,
  output logic                         last_of_run
);
  import hfe_pkg::*;

  state_t          state;
  state_t          state_next;
  logic [M_W-1:0]  m;
  logic [M_W-1:0]  len;
  logic [CW_W-1:0] flag;
  logic [7:0]      sreg;
  logic [3:0]      bitcnt;
  logic            last_in;
  logic            started;
  logic            started_next;

  enc_ctl_t        enc_ctl;
  enc_status_t     enc_status;

  logic            accept;
  logic            slot_free;
  logic            push;
  logic [CW_W-1:0] push_word;
  logic [1:0]      push_type;
  logic            push_last;
  logic            esc_need;

  hfe_serial_encoder u_enc (
    .clk    (clk),
    .rst    (rst),
    .ctl    (enc_ctl),
    .status (enc_status)
  );

  assign message_ready = (state == ST_IDLE);
  assign accept = message_valid && message_ready;
  assign slot_free = !result_valid || result_ready;
  assign esc_need = enc_status.all_zero || (enc_status.all_one && enc_status.fill == m);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      started <= 1'b0;
      m <= M_W'(4);
      len <= cw_len(M_W'(4));
      flag <= flag_word(M_W'(4));
    end else begin
      state <= state_next;
      started <= started_next;
      if (data_bits_write) begin
        m <= eff_m(data_bits);
        len <= cw_len(eff_m(data_bits));
        flag <= flag_word(eff_m(data_bits));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sreg <= message_byte;
      bitcnt <= 4'd8;
      last_in <= end_of_message;
    end else if (state == ST_SHIFT) begin
      sreg <= {sreg[6:0], 1'b0};
      bitcnt <= bitcnt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (push) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      codeword <= push_word;
      codeword_length <= len;
      frame_type <= push_type;
      last_of_run <= push_last;
    end
  end

  always_comb begin
    state_next = state;
    started_next = started;
    push = 1'b0;
    push_word = flag;
    push_type = TYPE_FLAG;
    push_last = 1'b0;
    enc_ctl.clear = data_bits_write;
    enc_ctl.shift = 1'b0;
    enc_ctl.bit_in = sreg[7];
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = started ? ST_SHIFT : ST_OPEN_FLAG;
        end
      end
      ST_OPEN_FLAG: begin
        if (slot_free) begin
          push = 1'b1;
          push_last = !last_in &&
                      (({1'b0, enc_status.fill} + (M_W+1)'(8)) < {1'b0, m});
          started_next = 1'b1;
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        enc_ctl.shift = 1'b1;
        if ((enc_status.fill + M_W'(1)) == m) begin
          state_next = ST_FRAME;
        end else if (bitcnt == 4'd1) begin
          state_next = last_in ? ST_FRAME : ST_IDLE;
        end
      end
      ST_FRAME: begin
        if (!esc_need) begin
          state_next = ST_DATA;
        end else if (slot_free) begin
          push = 1'b1;
          push_word = '0;
          push_type = TYPE_ESC;
          state_next = ST_DATA;
        end
      end
      ST_DATA: begin
        if (slot_free) begin
          push = 1'b1;
          push_word = enc_status.word;
          push_type = TYPE_DATA;
          push_last = !last_in && ({2'b00, bitcnt} < m);
          enc_ctl.clear = 1'b1;
          if (bitcnt != 4'd0) begin
            state_next = ST_SHIFT;
          end else if (last_in) begin
            state_next = ST_CLOSE_FLAG;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_CLOSE_FLAG: begin
        if (slot_free) begin
          push = 1'b1;
          push_last = 1'b1;
          started_next = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
